@@ hw/rtl/assert_macros.svh @@
// assertion macros included by the rtl back end
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define AFC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define AFC_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ hw/rtl/afc_pkg.sv @@
// shared types, constants and the predictor coefficient table
package afc_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int SAMPLE_W        = 16;
    localparam int PROD_W          = 32;
    localparam int ACC_W           = 34;
    localparam int FRAC_BITS       = 11;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    typedef struct packed {
        logic       clear;
        logic       two_bit;
        logic [3:0] scale;
        logic [3:0] coef;
        logic [7:0] data;
    } afc_cmd_t;

    typedef struct packed {
        logic signed [15:0] c0;
        logic signed [15:0] c1;
    } afc_coef_t;

    function automatic afc_coef_t coef_lookup(input logic [3:0] sel);
        afc_coef_t c;
        case (sel)
            4'd0:    c = '{16'sh0000, 16'sh0000};
            4'd1:    c = '{16'sh0800, 16'sh0000};
            4'd2:    c = '{16'sh0000, 16'sh0800};
            4'd3:    c = '{16'sh0400, 16'sh0400};
            4'd4:    c = '{16'sh1000, 16'shf800};
            4'd5:    c = '{16'sh0e00, 16'shfa00};
            4'd6:    c = '{16'sh0c00, 16'shfc00};
            4'd7:    c = '{16'sh1200, 16'shf600};
            4'd8:    c = '{16'sh1068, 16'shf738};
            4'd9:    c = '{16'sh12c0, 16'shf704};
            4'd10:   c = '{16'sh1400, 16'shf400};
            4'd11:   c = '{16'sh0800, 16'shf800};
            4'd12:   c = '{16'sh0400, 16'shfc00};
            4'd13:   c = '{16'shfc00, 16'sh0400};
            4'd14:   c = '{16'shfc00, 16'sh0000};
            4'd15:   c = '{16'shf800, 16'sh0000};
            default: c = '{16'sh0000, 16'sh0000};
        endcase
        return c;
    endfunction

endpackage

@@ hw/rtl/afc_if.sv @@
// valid/ready channel interfaces for compressed bytes and decoded samples
interface afc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       new_stream;

    modport source (output valid, output data_byte, output new_stream, input ready);
    modport sink   (input valid, input data_byte, input new_stream, output ready);
endinterface

interface afc_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic               last_of_byte;

    modport source (output valid, output sample, output last_of_byte, input ready);
    modport sink   (input valid, input sample, input last_of_byte, output ready);
endinterface

@@ hw/rtl/afc_adpcm_decoder_unit.sv @@
// afc adpcm decoder top level: byte input, sample output, mode register
// Takes the compressed stream one byte per beat. A header byte (scale in the high nibble,
// coefficient pair in the low nibble) gives no samples. A data byte is queued, then decoded by a
// multiply-accumulate loop that for each sample registers the products, then forms the sum,
// floor shift and saturation and loads the output register, stalling while that is full;
// after the last sample it returns to idle to pick up the next queued byte. Each sample
// feeds the predictor of the next, so that loop sets the rate. Up to QUEUE_DEPTH data bytes
// wait in the queue while the decoder works. The user must write two_bit_mode through cfg_we
// and cfg_wdata only while the block is idle; the block itself does not enforce this.
// new_stream on a byte clears the history and makes that byte a header.
module afc_adpcm_decoder_unit
    import afc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic          cfg_wdata,
    afc_byte_if.sink      in_chan,
    afc_sample_if.source  out_chan
);

    logic     two_bit_mode_reg;
    afc_cmd_t push_cmd;
    logic     push_valid;
    logic     push_ready;
    afc_cmd_t pop_cmd;
    logic     pop_valid;
    logic     pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            two_bit_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            two_bit_mode_reg <= cfg_wdata;
        end
    end

    afc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .two_bit_mode (two_bit_mode_reg),
        .in_chan      (in_chan),
        .cmd          (push_cmd),
        .cmd_valid    (push_valid),
        .cmd_ready    (push_ready)
    );

    afc_cmd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cmd   (push_cmd),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_cmd    (pop_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready)
    );

    afc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (pop_cmd),
        .cmd_valid (pop_valid),
        .cmd_ready (pop_ready),
        .out_chan  (out_chan)
    );

endmodule

@@ hw/rtl/afc_cmd_fifo.sv @@
// small register queue of decoded byte commands between front and back end
module afc_cmd_fifo
    import afc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  afc_cmd_t push_cmd,
    input  logic     push_valid,
    output logic     push_ready,
    output afc_cmd_t pop_cmd,
    output logic     pop_valid,
    input  logic     pop_ready
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    afc_cmd_t               mem_reg [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [CNT_W-1:0]       count_reg;
    logic                   do_push;
    logic                   do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ hw/rtl/afc_front.sv @@
// front end: tracks frame position, latches headers, queues data bytes
module afc_front
    import afc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      two_bit_mode,
    afc_byte_if.sink  in_chan,
    output afc_cmd_t  cmd,
    output logic      cmd_valid,
    input  logic      cmd_ready
);

    localparam logic [3:0] POS_HEADER    = 4'd0;
    localparam logic [3:0] LAST_POS_4BIT = 4'd8;
    localparam logic [3:0] LAST_POS_2BIT = 4'd4;

    logic [3:0] pos_reg;
    logic [3:0] scale_reg;
    logic [3:0] coef_reg;
    logic       clear_pend_reg;
    logic [3:0] pos_eff;
    logic [3:0] last_pos;
    logic       is_header;
    logic       accept;

    // new_stream restarts the frame, so that beat is always a header
    assign pos_eff   = in_chan.new_stream ? POS_HEADER : pos_reg;
    assign is_header = (pos_eff == POS_HEADER);
    assign last_pos  = two_bit_mode ? LAST_POS_2BIT : LAST_POS_4BIT;

    assign in_chan.ready = cmd_ready;
    assign accept        = in_chan.valid && in_chan.ready;
    assign cmd_valid     = in_chan.valid && !is_header;

    assign cmd.clear   = clear_pend_reg;
    assign cmd.two_bit = two_bit_mode;
    assign cmd.scale   = scale_reg;
    assign cmd.coef    = coef_reg;
    assign cmd.data    = in_chan.data_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= POS_HEADER;
            scale_reg      <= '0;
            coef_reg       <= '0;
            clear_pend_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (is_header)
            begin
                scale_reg <= in_chan.data_byte[7:4];
                coef_reg  <= in_chan.data_byte[3:0];
                pos_reg   <= 4'd1;
                if (in_chan.new_stream)
                begin
                    clear_pend_reg <= 1'b1;
                end
            end
            else
            begin
                // history clear rides along with the first data byte after it
                clear_pend_reg <= 1'b0;
                pos_reg        <= (pos_eff >= last_pos) ? POS_HEADER : pos_eff + 1'b1;
            end
        end
    end

endmodule

@@ hw/rtl/afc_back.sv @@
// back end: multiply-accumulate per sample, products registered before the sum, with output register
module afc_back
    import afc_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  afc_cmd_t        cmd,
    input  logic            cmd_valid,
    output logic            cmd_ready,
    afc_sample_if.source    out_chan
);

`include "assert_macros.svh"

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC
    } state_t;

    state_t                       state_reg;
    afc_cmd_t                     cur_reg;
    logic [1:0]                   idx_reg;
    logic signed [SAMPLE_W-1:0]   prev_reg;
    logic signed [SAMPLE_W-1:0]   older_reg;
    logic signed [PROD_W-1:0]     prod0_reg;
    logic signed [PROD_W-1:0]     prod1_reg;
    logic signed [ACC_W-1:0]      term_reg;
    logic                         out_valid_reg;
    logic signed [SAMPLE_W-1:0]   out_sample_reg;
    logic                         out_last_reg;

    afc_coef_t                    coef;
    logic signed [3:0]            code;
    logic signed [ACC_W-1:0]      code_ext;
    logic signed [ACC_W-1:0]      scaled;
    logic signed [ACC_W-1:0]      term_next;
    logic signed [PROD_W-1:0]     prod0_next;
    logic signed [PROD_W-1:0]     prod1_next;
    logic signed [ACC_W-1:0]      sum;
    logic signed [ACC_W-1:0]      shifted;
    logic signed [SAMPLE_W-1:0]   sat;
    logic                         out_free;
    logic                         last;

    assign cmd_ready = (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || out_chan.ready;
    assign last      = cur_reg.two_bit ? (idx_reg == 2'd3) : (idx_reg == 2'd1);
    assign coef      = coef_lookup(cur_reg.coef);

    // pick the code for this sample, most significant field first
    always_comb
    begin
        if (cur_reg.two_bit)
        begin
            case (idx_reg)
                2'd0:    code = {{2{cur_reg.data[7]}}, cur_reg.data[7:6]};
                2'd1:    code = {{2{cur_reg.data[5]}}, cur_reg.data[5:4]};
                2'd2:    code = {{2{cur_reg.data[3]}}, cur_reg.data[3:2]};
                default: code = {{2{cur_reg.data[1]}}, cur_reg.data[1:0]};
            endcase
        end
        else
        begin
            code = idx_reg[0] ? cur_reg.data[3:0] : cur_reg.data[7:4];
        end
    end

    // delta is a power of two, so delta*code is a shift; scale 15 means -32768
    always_comb
    begin
        code_ext = {{(ACC_W-4){code[3]}}, code};
        scaled   = code_ext <<< cur_reg.scale;
        if (cur_reg.scale == 4'd15)
        begin
            scaled = -scaled;
        end
        term_next = cur_reg.two_bit ? (scaled <<< 13) : (scaled <<< 11);
    end

    assign prod0_next = prev_reg * coef.c0;
    assign prod1_next = older_reg * coef.c1;

    always_comb
    begin
        sum     = term_reg
                + {{(ACC_W-PROD_W){prod0_reg[PROD_W-1]}}, prod0_reg}
                + {{(ACC_W-PROD_W){prod1_reg[PROD_W-1]}}, prod1_reg};
        shifted = sum >>> FRAC_BITS;
        if ((&shifted[ACC_W-1:SAMPLE_W-1]) || !(|shifted[ACC_W-1:SAMPLE_W-1]))
        begin
            sat = shifted[SAMPLE_W-1:0];
        end
        else
        begin
            sat = shifted[ACC_W-1] ? SAMPLE_MIN : SAMPLE_MAX;
        end
    end

    assign out_chan.valid        = out_valid_reg;
    assign out_chan.sample       = out_sample_reg;
    assign out_chan.last_of_byte = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cur_reg        <= '0;
            idx_reg        <= '0;
            prev_reg       <= '0;
            older_reg      <= '0;
            prod0_reg      <= '0;
            prod1_reg      <= '0;
            term_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_sample_reg <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_ACC && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_chan.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        cur_reg   <= cmd;
                        idx_reg   <= '0;
                        state_reg <= ST_MUL;
                        if (cmd.clear)
                        begin
                            prev_reg  <= '0;
                            older_reg <= '0;
                        end
                    end
                end
                ST_MUL:
                begin
                    prod0_reg <= prod0_next;
                    prod1_reg <= prod1_next;
                    term_reg  <= term_next;
                    state_reg <= ST_ACC;
                end
                ST_ACC:
                begin
                    if (out_free)
                    begin
                        out_sample_reg <= sat;
                        out_last_reg   <= last;
                        older_reg      <= prev_reg;
                        prev_reg       <= sat;
                        if (last)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= ST_MUL;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `AFC_ASSERT(a_acc_emits, (state_reg == ST_ACC && out_free) |=> out_valid_reg, "sample lost")
    `AFC_ASSERT(a_last_ends, (state_reg == ST_ACC && out_free && last) |=> (state_reg == ST_IDLE),
                "byte not closed")
    `AFC_ASSERT_NEVER(a_idx_range, state_reg != ST_IDLE && !cur_reg.two_bit && idx_reg[1],
                      "four-bit byte past second sample")

endmodule

@@ verif/afc_adpcm_decoder_unit_checker.sv @@
`timescale 1ns / 100ps
// sample predictor and scoreboard watching the byte, sample and mode ports of the decoder
module afc_adpcm_decoder_unit_checker
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   cfg_we,
    input  logic   cfg_wdata,
    afc_byte_if    byte_mon,
    afc_sample_if  sample_mon,
    output int     outstanding,
    output int     mismatches
);

    localparam int REPORT_LIMIT = 10;

    // predictor coefficient pairs, first and second tap
    localparam int PAIR_C0 [16] = '{
        0, 'h0800, 0, 'h0400, 'h1000, 'h0e00, 'h0c00, 'h1200,
        'h1068, 'h12c0, 'h1400, 'h0800, 'h0400, -'h0400, -'h0400, -'h0800
    };
    localparam int PAIR_C1 [16] = '{
        0, 0, 'h0800, 'h0400, -'h0800, -'h0600, -'h0400, -'h0a00,
        -'h08c8, -'h08fc, -'h0c00, -'h0800, -'h0400, 'h0400, 0, 0
    };

    typedef struct packed {
        logic signed [15:0] sample;
        logic               last;
    } pcm_beat_t;

    pcm_beat_t          expected_pcm [$];
    logic signed [15:0] hist1;
    logic signed [15:0] hist2;
    logic [3:0]         frame_pos;
    logic [3:0]         scale_exp;
    logic [3:0]         coef_idx;
    logic               two_bit;
    int                 err_count;

    function automatic logic signed [15:0] mac_sample(input logic [3:0] sc,
                                                      input logic [3:0] cf,
                                                      input logic signed [15:0] h1,
                                                      input logic signed [15:0] h2,
                                                      input int shifted);
        longint delta;
        longint acc;
        longint q;
        if (sc == 4'd15)
            delta = -32768;
        else
            delta = longint'(1) << sc;
        acc = delta * longint'(shifted)
            + longint'(h1) * longint'(PAIR_C0[cf])
            + longint'(h2) * longint'(PAIR_C1[cf]);
        q = acc >>> 11;
        if (q > 32767)
            q = 32767;
        else if (q < -32768)
            q = -32768;
        return q[15:0];
    endfunction

    task automatic take_byte(input logic [7:0] b, input logic ns);
        int        n_codes;
        int        code;
        int        shifted;
        logic [3:0] last_pos;
        pcm_beat_t e;
        if (ns)
        begin
            hist1     = '0;
            hist2     = '0;
            frame_pos = '0;
        end
        if (frame_pos == 4'd0)
        begin
            scale_exp = b[7:4];
            coef_idx  = b[3:0];
            frame_pos = 4'd1;
        end
        else
        begin
            last_pos = two_bit ? 4'd4 : 4'd8;
            n_codes  = two_bit ? 4 : 2;
            for (int k = 0; k < n_codes; k++)
            begin
                if (two_bit)
                begin
                    code = (int'(b) >> (6 - 2 * k)) & 3;
                    if (code >= 2)
                        code -= 4;
                    shifted = code * 8192;
                end
                else
                begin
                    code = (int'(b) >> (4 - 4 * k)) & 15;
                    if (code >= 8)
                        code -= 16;
                    shifted = code * 2048;
                end
                e.sample = mac_sample(scale_exp, coef_idx, hist1, hist2, shifted);
                e.last   = (k == n_codes - 1);
                expected_pcm.push_back(e);
                hist2 = hist1;
                hist1 = e.sample;
            end
            if (frame_pos >= last_pos)
                frame_pos = 4'd0;
            else
                frame_pos = frame_pos + 4'd1;
        end
    endtask

    task automatic check_beat(input logic signed [15:0] got_sample, input logic got_last);
        pcm_beat_t e;
        if (expected_pcm.size() == 0)
        begin
            if (err_count < REPORT_LIMIT)
                $display("unexpected sample beat: %0d last %0b", got_sample, got_last);
            err_count++;
        end
        else
        begin
            e = expected_pcm.pop_front();
            if (e.sample !== got_sample || e.last !== got_last)
            begin
                if (err_count < REPORT_LIMIT)
                    $display("sample mismatch: expected %0d last %0b, got %0d last %0b",
                             e.sample, e.last, got_sample, got_last);
                err_count++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_pcm.delete();
            hist1       = '0;
            hist2       = '0;
            frame_pos   = '0;
            scale_exp   = '0;
            coef_idx    = '0;
            two_bit     = 1'b0;
            err_count   = 0;
            outstanding <= 0;
            mismatches  <= 0;
        end
        else
        begin
            if (byte_mon.valid && byte_mon.ready)
                take_byte(byte_mon.data_byte, byte_mon.new_stream);
            if (sample_mon.valid && sample_mon.ready)
                check_beat(sample_mon.sample, sample_mon.last_of_byte);
            if (cfg_we)
                two_bit = cfg_wdata;
            outstanding <= expected_pcm.size();
            mismatches  <= err_count;
        end
    end

endmodule

@@ verif/afc_adpcm_decoder_unit_tb.sv @@
`timescale 1ns / 100ps
// testbench top for the afc adpcm decoder: clock, reset, byte stimulus, sample sink, verdict
module afc_adpcm_decoder_unit_tb;

    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 30;
    localparam int DRAIN_CYCLES  = 60;
    localparam int PHASE_ITEMS   = 58;
    localparam int IDLE_PCT      = 18;

    // {new_stream, data_byte}
    localparam logic [8:0] FOUR_BIT_SEQ [18] = '{
        9'h100, 9'h07f, 9'h080, 9'h008, 9'h0f0, 9'h000, 9'h0ff, 9'h012, 9'h034,
        9'h0f8, 9'h077, 9'h088, 9'h07f,
        9'h1b4, 9'h080, 9'h0ff,
        9'h10f, 9'h07f
    };
    // starts mid-frame so the shorter frame length ends it early
    localparam logic [8:0] TWO_BIT_SEQ [8] = '{
        9'h0ff, 9'h000, 9'h0aa,
        9'h1e9, 9'h055, 9'h0ff, 9'h080, 9'h07f
    };

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;
    int   outstanding;
    int   mismatches;
    int   sent = 0;
    bit   two_bit_now = 1'b0;
    bit   quiet = 1'b0;
    bit   broke = 1'b0;
    int   hold_asks = 0;
    int   hold_served = 0;

    afc_byte_if   byte_chan();
    afc_sample_if pcm_chan();

    afc_adpcm_decoder_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_chan   (byte_chan),
        .out_chan  (pcm_chan)
    );

    afc_adpcm_decoder_unit_checker pcm_check
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .byte_mon    (byte_chan),
        .sample_mon  (pcm_chan),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    // sample sink: random stalls, a long hold-off on request
    initial
    begin
        pcm_chan.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_served != hold_asks)
            begin
                pcm_chan.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_served++;
            end
            else
            begin
                pcm_chan.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic ns);
        if (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            byte_chan.valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
        end
        byte_chan.valid      <= 1'b1;
        byte_chan.data_byte  <= b;
        byte_chan.new_stream <= ns;
        @(posedge clk);
        while (!byte_chan.ready) @(posedge clk);
        sent++;
    endtask

    task automatic idle_bus();
        byte_chan.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    task automatic write_mode(input bit m);
        idle_bus();
        // a header beat gives no samples but may still be in flight
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we <= 1'b0;
        two_bit_now = m;
    endtask

    task automatic send_frame();
        int   kind;
        int   len;
        int   n;
        logic ns;
        kind = $urandom_range(99);
        len  = two_bit_now ? 4 : 8;
        if (kind < 8)
        begin
            // stray byte, possibly restarting the stream
            send_byte(8'($urandom), 1'($urandom_range(1)));
        end
        else
        begin
            ns = broke ? ($urandom_range(9) < 7) : ($urandom_range(99) < 15);
            n  = (kind < 18) ? $urandom_range(len - 1) : len;
            broke = (n < len);
            send_byte(8'($urandom), ns);
            for (int i = 0; i < n; i++)
                send_byte(8'($urandom), 1'b0);
        end
    endtask

    task automatic random_phase(input int count);
        int stop_at;
        stop_at = sent + count;
        while (sent < stop_at)
            send_frame();
    endtask

    initial
    begin
        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_wdata            <= 1'b0;
        byte_chan.valid      <= 1'b0;
        byte_chan.data_byte  <= '0;
        byte_chan.new_stream <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < $size(FOUR_BIT_SEQ); i++)
            send_byte(FOUR_BIT_SEQ[i][7:0], FOUR_BIT_SEQ[i][8]);
        write_mode(1'b1);
        for (int i = 0; i < $size(TWO_BIT_SEQ); i++)
            send_byte(TWO_BIT_SEQ[i][7:0], TWO_BIT_SEQ[i][8]);

        random_phase(PHASE_ITEMS);
        write_mode(1'b0);
        random_phase(PHASE_ITEMS);

        // sink holds off while bytes keep coming
        write_mode(1'b1);
        hold_asks++;
        random_phase(PHASE_ITEMS);

        write_mode(1'b0);
        quiet = 1'b1;
        random_phase(PHASE_ITEMS);
        quiet = 1'b0;

        // sender drains everything mid-phase
        write_mode(1'b1);
        random_phase(PHASE_ITEMS / 2);
        idle_bus();
        random_phase(PHASE_ITEMS / 2);

        write_mode(1'b0);
        random_phase(PHASE_ITEMS);

        idle_bus();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ afc_adpcm_decoder_unit.f @@
+incdir+hw/rtl
hw/rtl/afc_pkg.sv
hw/rtl/afc_if.sv
hw/rtl/afc_cmd_fifo.sv
hw/rtl/afc_front.sv
hw/rtl/afc_back.sv
hw/rtl/afc_adpcm_decoder_unit.sv
verif/afc_adpcm_decoder_unit_checker.sv
verif/afc_adpcm_decoder_unit_tb.sv
